>>> src/stb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the software timer bank.
// No dependencies; imported by the interfaces, the cell and the top level.
package stb_pkg;

  localparam int FUNC_W      = 3;
  localparam int CH_W        = 3;
  localparam int VAL_W       = 32;
  localparam int MAX_RESULTS = 8;
  localparam int FIRE_CNT_W  = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 3'd0,
    FN_SET   = 3'd1,
    FN_START = 3'd2,
    FN_STOP  = 3'd3,
    FN_RESET = 3'd4,
    FN_ALLOC = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_TICK,
    CELL_SET,
    CELL_START,
    CELL_STOP,
    CELL_RESET
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  period;
    logic              one_shot;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } walk_state_t;

endpackage

>>> src/stb_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results of the timer bank.
// Depends on stb_pkg for field widths.
interface stb_in_if;
  import stb_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CH_W-1:0]   channel;
  logic [VAL_W-1:0]  period_value;
  logic              one_shot;
  modport source (output valid, func, channel, period_value, one_shot, input ready);
  modport sink   (input valid, func, channel, period_value, one_shot, output ready);
endinterface

interface stb_out_if;
  import stb_pkg::*;
  logic             valid;
  logic             ready;
  logic             fired;
  logic [CH_W-1:0]  fired_channel;
  logic [CH_W-1:0]  handle;
  logic             handle_valid;
  logic [VAL_W-1:0] tick_count;
  logic             last;
  modport source (output valid, fired, fired_channel, handle, handle_valid, tick_count, last,
                  input ready);
  modport sink   (input valid, fired, fired_channel, handle, handle_valid, tick_count, last,
                  output ready);
endinterface

>>> src/stb_cell.sv
`timescale 1ns / 1ps
// One timer channel: enable, mode, count, reload and a fire-pending flag.
// Passes the report token to its neighbour; depends on stb_pkg.
module stb_cell import stb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  logic      sel,
  input  logic      active,
  input  logic      token_in,
  input  logic      advance,
  output logic      token_out,
  output logic      pending
);

  logic             enable_r, enable_nxt;
  logic             one_shot_r, one_shot_nxt;
  logic [VAL_W-1:0] count_r, count_nxt;
  logic [VAL_W-1:0] reload_r, reload_nxt;
  logic             pending_r, pending_nxt;
  logic             token_r, token_nxt;
  logic [VAL_W-1:0] count_dec;

  assign count_dec = count_r - VAL_W'(1);

  always_comb begin
    enable_nxt   = enable_r;
    one_shot_nxt = one_shot_r;
    count_nxt    = count_r;
    reload_nxt   = reload_r;
    pending_nxt  = pending_r;
    token_nxt    = token_r;
    unique case (cmd.op)
      CELL_TICK: begin
        pending_nxt = 1'b0;
        token_nxt   = token_in;
        if (active && enable_r) begin
          if (count_dec == '0) begin
            count_nxt   = reload_r;
            pending_nxt = 1'b1;
            if (one_shot_r) enable_nxt = 1'b0;
          end else begin
            count_nxt = count_dec;
          end
        end
      end
      CELL_SET: begin
        if (sel) begin
          one_shot_nxt = cmd.one_shot;
          count_nxt    = cmd.period;
          reload_nxt   = cmd.period;
        end
      end
      CELL_START: begin
        if (sel) begin
          count_nxt  = reload_r;
          enable_nxt = 1'b1;
        end
      end
      CELL_STOP: begin
        if (sel) enable_nxt = 1'b0;
      end
      CELL_RESET: begin
        if (sel) begin
          enable_nxt = 1'b0;
          count_nxt  = reload_r;
        end
      end
      CELL_NOP: begin
        if (advance) begin
          token_nxt = token_in;
          if (token_r) pending_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      one_shot_r <= 1'b0;
      count_r    <= '0;
      reload_r   <= '0;
      pending_r  <= 1'b0;
      token_r    <= 1'b0;
    end else begin
      enable_r   <= enable_nxt;
      one_shot_r <= one_shot_nxt;
      count_r    <= count_nxt;
      reload_r   <= reload_nxt;
      pending_r  <= pending_nxt;
      token_r    <= token_nxt;
    end
  end

  assign token_out = token_r;
  assign pending   = pending_r;

endmodule

>>> src/software_timer_bank.sv
`timescale 1ns / 1ps
// Timer bank top: command decode, cell chain, report walk and result register.
// A non-tick command writes the result register when it is accepted; a tick starts
// a walk in which the report token steps one cell per advance, holding while a fired
// result waits on a stalled output. Only one transaction is handled at a time.
// Synchronous active-low reset clears every channel, the allocator and tick counter.
// Depends on stb_pkg, stb_ifs and stb_cell.
module software_timer_bank import stb_pkg::*; #(
  parameter int NUM_TIMERS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  stb_in_if.sink    in_ch,
  stb_out_if.source out_ch
);

  localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ALLOC_W = $clog2(NUM_TIMERS + 1);

  walk_state_t state_r, state_nxt;

  logic [IDX_W-1:0]      walk_idx_r, walk_idx_nxt;
  logic [FIRE_CNT_W-1:0] fired_cnt_r, fired_cnt_nxt;
  logic [ALLOC_W-1:0]    alloc_cnt_r, alloc_cnt_nxt;
  logic [VAL_W-1:0]      tick_cnt_r, tick_cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_fired_r, out_fired_nxt;
  logic [CH_W-1:0]  out_fch_r, out_fch_nxt;
  logic [CH_W-1:0]  out_hnd_r, out_hnd_nxt;
  logic             out_hvalid_r, out_hvalid_nxt;
  logic [VAL_W-1:0] out_tick_r, out_tick_nxt;
  logic             out_last_r, out_last_nxt;

  logic                  out_free, in_fire, is_tick, emit, advance, walk_done, alloc_ok;
  logic                  hit_any, pend_above;
  logic [NUM_TIMERS-1:0] token_vec, pend_vec, sel_vec, active_vec, chain_in;
  logic [NUM_TIMERS-1:0] pend_shift;
  cell_cmd_t             cmd;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign is_tick   = (func_t'(in_ch.func) == FN_TICK);
  assign alloc_ok  = (alloc_cnt_r < ALLOC_W'(NUM_TIMERS));
  assign hit_any   = |(token_vec & pend_vec);
  assign pend_shift = pend_vec >> walk_idx_r;
  assign pend_above = |(pend_shift >> 1);
  assign walk_done  = (walk_idx_r == IDX_W'(NUM_TIMERS - 1));

  // command broadcast to the cells
  always_comb begin
    cmd.period   = in_ch.period_value;
    cmd.one_shot = in_ch.one_shot;
    cmd.op       = CELL_NOP;
    if (in_fire) begin
      unique case (func_t'(in_ch.func))
        FN_TICK:  cmd.op = CELL_TICK;
        FN_SET:   cmd.op = CELL_SET;
        FN_START: cmd.op = CELL_START;
        FN_STOP:  cmd.op = CELL_STOP;
        FN_RESET: cmd.op = CELL_RESET;
        default:  cmd.op = CELL_NOP;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    assign sel_vec[g]    = (int'(in_ch.channel) == g);
    assign active_vec[g] = (ALLOC_W'(g) < alloc_cnt_r);
    if (g == 0) begin : g_head
      assign chain_in[g] = in_fire && is_tick;
    end else begin : g_link
      assign chain_in[g] = token_vec[g-1];
    end
    stb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (sel_vec[g]),
      .active    (active_vec[g]),
      .token_in  (chain_in[g]),
      .advance   (advance),
      .token_out (token_vec[g]),
      .pending   (pend_vec[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire && is_tick) state_nxt = ST_WALK;
      ST_WALK:   if (advance && walk_done) state_nxt = ST_FINISH;
      ST_FINISH: if (fired_cnt_r != '0 || out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ch.ready    = 1'b0;
    emit           = 1'b0;
    advance        = 1'b0;
    walk_idx_nxt   = walk_idx_r;
    fired_cnt_nxt  = fired_cnt_r;
    alloc_cnt_nxt  = alloc_cnt_r;
    tick_cnt_nxt   = tick_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_fired_nxt  = out_fired_r;
    out_fch_nxt    = out_fch_r;
    out_hnd_nxt    = out_hnd_r;
    out_hvalid_nxt = out_hvalid_r;
    out_tick_nxt   = out_tick_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = out_free;
        if (in_fire) begin
          if (is_tick) begin
            tick_cnt_nxt  = tick_cnt_r + VAL_W'(1);
            walk_idx_nxt  = '0;
            fired_cnt_nxt = '0;
          end else begin
            out_valid_nxt  = 1'b1;
            out_fired_nxt  = 1'b0;
            out_fch_nxt    = '0;
            out_hnd_nxt    = '0;
            out_hvalid_nxt = 1'b0;
            out_tick_nxt   = tick_cnt_r;
            out_last_nxt   = 1'b1;
            if (func_t'(in_ch.func) == FN_ALLOC && alloc_ok) begin
              out_hnd_nxt    = CH_W'(alloc_cnt_r);
              out_hvalid_nxt = 1'b1;
              alloc_cnt_nxt  = alloc_cnt_r + ALLOC_W'(1);
            end
          end
        end
      end
      ST_WALK: begin
        emit    = hit_any && (fired_cnt_r < FIRE_CNT_W'(MAX_RESULTS));
        advance = !emit || out_free;
        if (advance) walk_idx_nxt = walk_idx_r + IDX_W'(1);
        if (emit && out_free) begin
          fired_cnt_nxt  = fired_cnt_r + FIRE_CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = 1'b1;
          out_fch_nxt    = CH_W'(walk_idx_r);
          out_hnd_nxt    = '0;
          out_hvalid_nxt = 1'b0;
          out_tick_nxt   = tick_cnt_r;
          out_last_nxt   = !pend_above || (fired_cnt_r == FIRE_CNT_W'(MAX_RESULTS - 1));
        end
      end
      ST_FINISH: begin
        if (fired_cnt_r == '0 && out_free) begin
          out_valid_nxt  = 1'b1;
          out_fired_nxt  = 1'b0;
          out_fch_nxt    = '0;
          out_hnd_nxt    = '0;
          out_hvalid_nxt = 1'b0;
          out_tick_nxt   = tick_cnt_r;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_idx_r  <= '0;
      fired_cnt_r <= '0;
      alloc_cnt_r <= '0;
      tick_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_idx_r  <= walk_idx_nxt;
      fired_cnt_r <= fired_cnt_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_fired_r  <= out_fired_nxt;
    out_fch_r    <= out_fch_nxt;
    out_hnd_r    <= out_hnd_nxt;
    out_hvalid_r <= out_hvalid_nxt;
    out_tick_r   <= out_tick_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fired         = out_fired_r;
  assign out_ch.fired_channel = out_fch_r;
  assign out_ch.handle        = out_hnd_r;
  assign out_ch.handle_valid  = out_hvalid_r;
  assign out_ch.tick_count    = out_tick_r;
  assign out_ch.last          = out_last_r;

endmodule
